// ----- rtl/core/mfd_pkg.sv -----
// mfd_pkg: types and constants shared by the metering frame decoder core
// and its users: word types, status and register codes, frame layout.
// No dependencies.
package mfd_pkg;

  // frame layout
  localparam int unsigned FRAME_LEN   = 24;
  localparam int unsigned COUNT_SAT   = 25;
  localparam int unsigned SUM_FIRST   = 2;
  localparam int unsigned SUM_LAST    = 22;
  localparam int unsigned SUM_POS     = 23;
  localparam int unsigned HDR_POS     = 0;
  localparam int unsigned ADJ_POS     = 20;
  localparam int unsigned V_COEF_POS  = 2;
  localparam int unsigned V_PER_POS   = 5;
  localparam int unsigned I_COEF_POS  = 8;
  localparam int unsigned I_PER_POS   = 11;
  localparam int unsigned P_COEF_POS  = 14;
  localparam int unsigned P_PER_POS   = 17;
  localparam logic [7:0]  HEADER_BYTE = 8'h55;
  localparam logic [7:0]  ADJ_MASK    = 8'h70;

  // arithmetic widths
  localparam int unsigned COEF_W = 24;
  localparam int unsigned VAL_W  = 40;
  localparam int unsigned CAL_W  = 48;
  localparam int unsigned REG_W  = 32;
  localparam logic signed [REG_W-1:0] GAIN_RESET = 32'sh0001_0000;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_LEN  = 3'd1,
    ST_BAD_HDR  = 3'd2,
    ST_ADJ_INC  = 3'd3,
    ST_CSUM     = 3'd4,
    ST_ZERO_DIV = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    REG_POWER_GAIN     = 2'd0,
    REG_POWER_OFFSET   = 2'd1,
    REG_CURRENT_GAIN   = 2'd2,
    REG_CURRENT_OFFSET = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    Q_VOLT  = 2'd0,
    Q_CURR  = 2'd1,
    Q_POWER = 2'd2
  } qty_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV_RUN,
    S_DIV_END,
    S_CAL_LO,
    S_CAL_HI,
    S_CAL_SUM,
    S_DONE
  } fsm_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    status_e                  status;
    logic [7:0]               code_byte;
    logic [VAL_W-1:0]         voltage_value;
    logic signed [CAL_W-1:0]  current_value;
    logic signed [CAL_W-1:0]  power_value;
  } out_word_t;

  // sequencer controls towards the datapath
  typedef struct packed {
    logic chk_capture;
    logic div_load;
    logic div_step;
    logic div_capture;
    logic mul_lo;
    logic mul_hi;
    logic cal_sum;
    logic out_load;
    logic sel_set;
    qty_e sel_nxt;
  } ctrl_t;

endpackage

// ----- rtl/core/metering_frame_decoder_core.sv -----
// metering_frame_decoder_core: collects 24-byte meter frames, checks them
// and decodes voltage, current and power through one shared serial divider
// and one shared multiplier. Depends on mfd_pkg.
// Usage
// - input channel in_valid_i/in_ready_o carries one byte word per handshake
//   with a last-byte marker; non-final bytes are taken back to back in idle
// - the final byte starts the decode; in_ready_o stays low until the result
//   word has been moved into the output register
// - a frame that fails the length, header, adjustment or checksum check, or
//   has a zero period, skips the divider and goes from check straight to done
// - a good frame runs three restoring divisions of 24+FRAC_BITS steps each
//   (one quotient bit a cycle, then a state that collects the quotient) and
//   two calibrations, each a low-half product, a high-half product and an
//   offset sum
// - results wait in an output register; bytes of the next frame are taken
//   while it waits, and a further final byte holds in the done state until
//   the receiver takes the pending word
// - reset empties the byte counter and the checksum, sets gains to 1.0 and
//   offsets to 0; the frame store holds no reset value
// - configuration writes take effect at once and belong in idle periods
module metering_frame_decoder_core #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  mfd_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mfd_pkg::out_word_t out_word_o
);
  import mfd_pkg::*;

  localparam int unsigned DIV_W    = COEF_W + FRAC_BITS;
  localparam int unsigned CNT_W    = $clog2(DIV_W);
  localparam int unsigned UP_SHIFT = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int unsigned DN_SHIFT = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
  localparam int unsigned MUL_W    = REG_W + 21;
  localparam int unsigned ACC_W    = 72;
  localparam int unsigned SUM_W    = 58;

  // frame capture state
  logic [7:0]             store_q [FRAME_LEN];
  logic [4:0]             cnt_q;
  logic [7:0]             sum_q;
  logic                   len_ok_q;

  // calibration registers
  logic signed [REG_W-1:0] pgain_q, poff_q, cgain_q, coff_q;

  // sequencer
  fsm_e                   state_q, state_d;
  qty_e                   sel_q;
  ctrl_t                  ctrl;

  // shared divider
  logic [DIV_W-1:0]       quo_q;
  logic [COEF_W-1:0]      rem_q;
  logic [COEF_W-1:0]      per_q;
  logic [CNT_W-1:0]       step_q;

  // results
  logic [VAL_W-1:0]       volt_q, x_q;
  logic signed [MUL_W-1:0] plo_q, phi_q;
  logic signed [CAL_W-1:0] curr_q, pwr_q;
  status_e                stat_q;
  logic [7:0]             code_q;
  logic                   out_valid_q;
  out_word_t              out_word_q;

  logic                   in_acc;
  status_e                chk_status;
  logic [7:0]             chk_code;
  logic [COEF_W-1:0]      v_per, i_per, p_per;
  logic [COEF_W-1:0]      ld_coef, ld_per;
  logic [COEF_W:0]        shifted;
  logic [COEF_W+1:0]      diff;
  logic [CAL_W-1:0]       quo_ext;
  logic [VAL_W-1:0]       quo_sat;
  logic signed [REG_W-1:0] cal_gain, cal_off;
  logic [19:0]            mul_x;
  logic signed [MUL_W-1:0] mul_p;
  logic signed [ACC_W-1:0] acc;
  logic signed [SUM_W-1:0] off_ext, offs, cal_sum;
  logic signed [CAL_W-1:0] cal_sat;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pgain_q <= GAIN_RESET;
      poff_q  <= '0;
      cgain_q <= GAIN_RESET;
      coff_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_POWER_GAIN:     pgain_q <= cfg_wdata_i;
        REG_POWER_OFFSET:   poff_q  <= cfg_wdata_i;
        REG_CURRENT_GAIN:   cgain_q <= cfg_wdata_i;
        REG_CURRENT_OFFSET: coff_q  <= cfg_wdata_i;
      endcase
    end
  end

  // frame store, written in byte order
  always_ff @(posedge clk_i) begin
    if (in_acc && (cnt_q < 5'(FRAME_LEN))) begin
      store_q[cnt_q] <= in_word_i.data_byte;
    end
  end

  // byte counter, length flag and running checksum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      sum_q    <= '0;
      len_ok_q <= 1'b0;
    end else begin
      if (in_acc) begin
        if (in_word_i.last_byte) begin
          cnt_q    <= '0;
          len_ok_q <= (cnt_q == 5'(FRAME_LEN - 1));
        end else if (cnt_q < 5'(COUNT_SAT)) begin
          cnt_q <= cnt_q + 5'd1;
        end
        if ((cnt_q >= 5'(SUM_FIRST)) && (cnt_q <= 5'(SUM_LAST))) begin
          sum_q <= sum_q + in_word_i.data_byte;
        end
      end else if (ctrl.out_load) begin
        sum_q <= '0;
      end
    end
  end

  // frame checks in priority order
  assign v_per = {store_q[V_PER_POS], store_q[V_PER_POS+1], store_q[V_PER_POS+2]};
  assign i_per = {store_q[I_PER_POS], store_q[I_PER_POS+1], store_q[I_PER_POS+2]};
  assign p_per = {store_q[P_PER_POS], store_q[P_PER_POS+1], store_q[P_PER_POS+2]};

  always_comb begin
    chk_status = ST_OK;
    chk_code   = '0;
    priority if (!len_ok_q) begin
      chk_status = ST_BAD_LEN;
    end else if (store_q[HDR_POS] != HEADER_BYTE) begin
      chk_status = ST_BAD_HDR;
      chk_code   = store_q[HDR_POS];
    end else if ((store_q[ADJ_POS] & ADJ_MASK) != ADJ_MASK) begin
      chk_status = ST_ADJ_INC;
      chk_code   = store_q[ADJ_POS];
    end else if (sum_q != store_q[SUM_POS]) begin
      chk_status = ST_CSUM;
    end else if ((v_per == '0) || (i_per == '0) || (p_per == '0)) begin
      chk_status = ST_ZERO_DIV;
    end else begin
      chk_status = ST_OK;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:    if (in_acc && in_word_i.last_byte) state_d = S_CHECK;
      S_CHECK:   state_d = (chk_status == ST_OK) ? S_DIV_RUN : S_DONE;
      S_DIV_RUN: if (step_q == CNT_W'(DIV_W - 1)) state_d = S_DIV_END;
      S_DIV_END: state_d = (sel_q == Q_VOLT) ? S_DIV_RUN : S_CAL_LO;
      S_CAL_LO:  state_d = S_CAL_HI;
      S_CAL_HI:  state_d = S_CAL_SUM;
      S_CAL_SUM: state_d = (sel_q == Q_CURR) ? S_DIV_RUN : S_DONE;
      S_DONE:    if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    ctrl = '0;
    ctrl.sel_nxt = Q_VOLT;
    unique case (state_q)
      S_CHECK: begin
        ctrl.chk_capture = 1'b1;
        if (chk_status == ST_OK) begin
          ctrl.div_load = 1'b1;
          ctrl.sel_set  = 1'b1;
          ctrl.sel_nxt  = Q_VOLT;
        end
      end
      S_DIV_RUN: ctrl.div_step = 1'b1;
      S_DIV_END: begin
        ctrl.div_capture = 1'b1;
        if (sel_q == Q_VOLT) begin
          ctrl.div_load = 1'b1;
          ctrl.sel_set  = 1'b1;
          ctrl.sel_nxt  = Q_CURR;
        end
      end
      S_CAL_LO: ctrl.mul_lo = 1'b1;
      S_CAL_HI: ctrl.mul_hi = 1'b1;
      S_CAL_SUM: begin
        ctrl.cal_sum = 1'b1;
        if (sel_q == Q_CURR) begin
          ctrl.div_load = 1'b1;
          ctrl.sel_set  = 1'b1;
          ctrl.sel_nxt  = Q_POWER;
        end
      end
      S_DONE: ctrl.out_load = !out_valid_q || out_ready_i;
      default: ctrl = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sel_q   <= Q_VOLT;
    end else begin
      state_q <= state_d;
      if (ctrl.sel_set) sel_q <= ctrl.sel_nxt;
    end
  end

  // divider operands for the quantity being loaded
  always_comb begin
    unique case (ctrl.sel_nxt)
      Q_VOLT: begin
        ld_coef = {store_q[V_COEF_POS], store_q[V_COEF_POS+1], store_q[V_COEF_POS+2]};
        ld_per  = v_per;
      end
      Q_CURR: begin
        ld_coef = {store_q[I_COEF_POS], store_q[I_COEF_POS+1], store_q[I_COEF_POS+2]};
        ld_per  = i_per;
      end
      Q_POWER: begin
        ld_coef = {store_q[P_COEF_POS], store_q[P_COEF_POS+1], store_q[P_COEF_POS+2]};
        ld_per  = p_per;
      end
      default: begin
        ld_coef = '0;
        ld_per  = '0;
      end
    endcase
  end

  // restoring divider step: one quotient bit a cycle
  assign shifted = {rem_q, quo_q[DIV_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, per_q};
  assign quo_ext = CAL_W'(quo_q);
  assign quo_sat = (|quo_ext[CAL_W-1:VAL_W]) ? '1 : quo_ext[VAL_W-1:0];

  always_ff @(posedge clk_i) begin
    if (ctrl.div_load) begin
      quo_q  <= {ld_coef, {FRAC_BITS{1'b0}}};
      rem_q  <= '0;
      per_q  <= ld_per;
      step_q <= '0;
    end else if (ctrl.div_step) begin
      step_q <= step_q + CNT_W'(1);
      if (!diff[COEF_W+1]) begin
        rem_q <= diff[COEF_W-1:0];
        quo_q <= {quo_q[DIV_W-2:0], 1'b1};
      end else begin
        rem_q <= shifted[COEF_W-1:0];
        quo_q <= {quo_q[DIV_W-2:0], 1'b0};
      end
    end
  end

  // calibration: gain times ratio in two 20-bit halves, then offset add
  assign cal_gain = (sel_q == Q_CURR) ? cgain_q : pgain_q;
  assign cal_off  = (sel_q == Q_CURR) ? coff_q : poff_q;
  assign mul_x    = ctrl.mul_hi ? x_q[VAL_W-1:20] : x_q[19:0];
  assign mul_p    = cal_gain * $signed({1'b0, mul_x});

  assign acc     = {{(ACC_W-MUL_W){plo_q[MUL_W-1]}}, plo_q}
                 + ({{(ACC_W-MUL_W){phi_q[MUL_W-1]}}, phi_q} <<< 20);
  assign off_ext = {{(SUM_W-REG_W){cal_off[REG_W-1]}}, cal_off};
  assign offs    = (off_ext <<< UP_SHIFT) >>> DN_SHIFT;
  assign cal_sum = {{2{acc[ACC_W-1]}}, acc[ACC_W-1:16]} + offs;

  // saturate to the signed 48-bit range
  always_comb begin
    if ((&cal_sum[SUM_W-1:CAL_W-1]) || !(|cal_sum[SUM_W-1:CAL_W-1])) begin
      cal_sat = cal_sum[CAL_W-1:0];
    end else if (cal_sum[SUM_W-1]) begin
      cal_sat = {1'b1, {(CAL_W-1){1'b0}}};
    end else begin
      cal_sat = {1'b0, {(CAL_W-1){1'b1}}};
    end
  end

  // result collection
  always_ff @(posedge clk_i) begin
    if (ctrl.chk_capture) begin
      stat_q <= chk_status;
      code_q <= chk_code;
      volt_q <= '0;
      curr_q <= '0;
      pwr_q  <= '0;
    end
    if (ctrl.div_capture) begin
      if (sel_q == Q_VOLT) volt_q <= quo_sat;
      else x_q <= quo_sat;
    end
    if (ctrl.mul_lo) plo_q <= mul_p;
    if (ctrl.mul_hi) phi_q <= mul_p;
    if (ctrl.cal_sum) begin
      if (sel_q == Q_CURR) curr_q <= cal_sat;
      else pwr_q <= cal_sat;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.out_load) begin
      out_word_q.status        <= stat_q;
      out_word_q.code_byte     <= code_q;
      out_word_q.voltage_value <= volt_q;
      out_word_q.current_value <= curr_q;
      out_word_q.power_value   <= pwr_q;
    end
  end

endmodule
